>>> rtl/bti_pkg.sv
package bti_pkg;

  // storage sizes
  localparam int unsigned PROG_DEPTH = 4096;
  localparam int unsigned TAPE_DEPTH = 32768;
  localparam int unsigned PA_W       = $clog2(PROG_DEPTH);
  localparam int unsigned PC_W       = PA_W + 1;
  localparam int unsigned TA_W       = $clog2(TAPE_DEPTH);

  // func codes of an input word
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_EXEC  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // program characters
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  // micro operations driving the datapath
  typedef enum logic [2:0] {
    U_SWEEP,
    U_FETCH,
    U_EXEC,
    U_LOAD,
    U_LINK1,
    U_LINK2,
    U_CINIT,
    U_NOP
  } uop_e;

  // sequencing conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_DISPATCH,
    C_NOT_LAST,
    C_NO_LINK
  } cond_e;

  typedef logic [3:0] upc_t;

  // control store addresses
  localparam upc_t A_RSWEEP = 4'd0;
  localparam upc_t A_FETCH  = 4'd1;
  localparam upc_t A_EXEC   = 4'd2;
  localparam upc_t A_LOAD   = 4'd3;
  localparam upc_t A_LINK1  = 4'd4;
  localparam upc_t A_LINK2  = 4'd5;
  localparam upc_t A_CINIT  = 4'd6;
  localparam upc_t A_CSWEEP = 4'd7;
  localparam upc_t A_POST   = 4'd8;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    upc_t  target;
    logic  post;
  } cw_t;

  // control store: one control word per step
  function automatic cw_t ucode(upc_t addr);
    cw_t cw;
    case (addr)
      A_RSWEEP: cw = '{op: U_SWEEP, cond: C_NOT_LAST, target: A_RSWEEP, post: 1'b0};
      A_FETCH:  cw = '{op: U_FETCH, cond: C_DISPATCH, target: A_FETCH,  post: 1'b0};
      A_EXEC:   cw = '{op: U_EXEC,  cond: C_ALWAYS,   target: A_FETCH,  post: 1'b1};
      A_LOAD:   cw = '{op: U_LOAD,  cond: C_NO_LINK,  target: A_POST,   post: 1'b0};
      A_LINK1:  cw = '{op: U_LINK1, cond: C_NEXT,     target: A_LINK2,  post: 1'b0};
      A_LINK2:  cw = '{op: U_LINK2, cond: C_ALWAYS,   target: A_POST,   post: 1'b0};
      A_CINIT:  cw = '{op: U_CINIT, cond: C_NEXT,     target: A_CSWEEP, post: 1'b0};
      A_CSWEEP: cw = '{op: U_SWEEP, cond: C_NOT_LAST, target: A_CSWEEP, post: 1'b0};
      A_POST:   cw = '{op: U_NOP,   cond: C_ALWAYS,   target: A_FETCH,  post: 1'b1};
      default:  cw = '{op: U_NOP,   cond: C_ALWAYS,   target: A_FETCH,  post: 1'b0};
    endcase
    return cw;
  endfunction

endpackage

>>> rtl/byte_tape_interpreter_core.sv
// execute word: accepted in FETCH, then EXEC writes the result register; a new word is taken only in FETCH
// load word: LOAD then POST, with LINK1 and LINK2 between when a ']' closes an open bracket
// clear word: CINIT, then the one-cell-a-cycle tape sweep, then POST
// result register lets the next word be accepted while a result waits
// reset (rst_ni low, async) clears control state, then a tape sweep clears all
// TAPE_DEPTH cells before the first word is accepted
module byte_tape_interpreter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_stall_o,
  input  logic [1:0] func_i,
  input  logic [7:0] program_char_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       halted_o,
  output logic       compile_error_o,
  output logic       load_overflow_o,
  output logic [bti_pkg::PC_W-1:0] program_counter_o
);
  import bti_pkg::*;

  // memories
  logic [7:0]      prog_mem  [PROG_DEPTH];
  logic [PA_W-1:0] jt_mem    [PROG_DEPTH];
  logic [PA_W-1:0] stack_mem [PROG_DEPTH];
  logic [7:0]      tape_mem  [TAPE_DEPTH];

  // sequencer and architectural state
  upc_t            upc_q, upc_d;
  logic [TA_W-1:0] sweep_cnt_q, sweep_cnt_d;
  logic [PC_W-1:0] len_q, len_d;
  logic [PC_W-1:0] depth_q, depth_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [TA_W-1:0] tp_q, tp_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      char_q, char_d;
  logic [PA_W-1:0] link_pos_q, link_pos_d;

  // registered read data
  logic [7:0]      prog_rd_q;
  logic [PA_W-1:0] jt_rd_q;
  logic [PA_W-1:0] stack_rd_q;
  logic [7:0]      tape_rd_q;

  // result register
  logic            res_valid_q, res_valid_d;
  logic            r_emit_q, r_emit_d;
  logic [7:0]      r_byte_q, r_byte_d;
  logic            r_halt_q, r_halt_d;
  logic            r_cerr_q, r_cerr_d;
  logic            r_ovf_q, r_ovf_d;
  logic [PC_W-1:0] r_pc_q, r_pc_d;

  // memory port controls
  logic            prog_we, fetch_re, stack_we, stack_re, jt_we, tape_we;
  logic [PA_W-1:0] jt_waddr, jt_wdata, stack_waddr, stack_raddr;
  logic [TA_W-1:0] tape_waddr;
  logic [7:0]      tape_wdata;

  cw_t             cw;
  logic            accept, hold, sweep_last, full, link, cerr, run, emit;
  logic [PC_W-1:0] nxt_pc, depth_dec;

  assign req_stall_o = (upc_q != A_FETCH);
  assign accept      = req_valid_i && !req_stall_o;

  // control word decode and datapath
  always_comb begin
    cw          = ucode(upc_q);
    hold        = cw.post && res_valid_q && res_stall_i;
    sweep_last  = (sweep_cnt_q == TA_W'(TAPE_DEPTH - 1));
    full        = (len_q >= PC_W'(PROG_DEPTH));
    link        = !full && (char_q == CH_CLOSE) && (depth_q != '0);
    cerr        = (depth_q != '0);
    run         = !cerr && (pc_q < len_q);
    depth_dec   = depth_q - PC_W'(1);
    nxt_pc      = pc_q + PC_W'(1);
    emit        = 1'b0;

    upc_d       = upc_q;
    sweep_cnt_d = sweep_cnt_q;
    len_d       = len_q;
    depth_d     = depth_q;
    pc_d        = pc_q;
    tp_d        = tp_q;
    ovf_d       = ovf_q;
    char_d      = char_q;
    link_pos_d  = link_pos_q;

    prog_we     = 1'b0;
    fetch_re    = 1'b0;
    stack_we    = 1'b0;
    stack_re    = 1'b0;
    jt_we       = 1'b0;
    tape_we     = 1'b0;
    jt_waddr    = len_q[PA_W-1:0];
    jt_wdata    = '0;
    stack_waddr = depth_q[PA_W-1:0];
    stack_raddr = depth_dec[PA_W-1:0];
    tape_waddr  = tp_q;
    tape_wdata  = '0;

    // drain the result register
    res_valid_d = res_valid_q && res_stall_i;
    r_emit_d    = r_emit_q;
    r_byte_d    = r_byte_q;
    r_halt_d    = r_halt_q;
    r_cerr_d    = r_cerr_q;
    r_ovf_d     = r_ovf_q;
    r_pc_d      = r_pc_q;

    case (cw.op)
      U_SWEEP: begin
        tape_we     = 1'b1;
        tape_waddr  = sweep_cnt_q;
        sweep_cnt_d = sweep_last ? '0 : sweep_cnt_q + TA_W'(1);
      end
      U_FETCH: begin
        fetch_re = 1'b1;
        if (accept) begin
          char_d = program_char_i;
          ovf_d  = 1'b0;
        end
      end
      U_EXEC: begin
        if (run) begin
          case (prog_rd_q)
            CH_RIGHT: tp_d = (tp_q == TA_W'(TAPE_DEPTH - 1)) ? '0 : tp_q + TA_W'(1);
            CH_LEFT:  tp_d = (tp_q == '0) ? TA_W'(TAPE_DEPTH - 1) : tp_q - TA_W'(1);
            CH_PLUS: begin
              tape_we    = !hold;
              tape_wdata = tape_rd_q + 8'd1;
            end
            CH_MINUS: begin
              tape_we    = !hold;
              tape_wdata = tape_rd_q - 8'd1;
            end
            CH_DOT:   emit = 1'b1;
            CH_OPEN: begin
              if (tape_rd_q == 8'd0) nxt_pc = {1'b0, jt_rd_q} + PC_W'(1);
            end
            CH_CLOSE: begin
              if (tape_rd_q != 8'd0) nxt_pc = {1'b0, jt_rd_q};
            end
            default: ;
          endcase
          pc_d = nxt_pc;
        end
        r_emit_d = emit;
        r_byte_d = emit ? tape_rd_q : 8'd0;
        r_cerr_d = cerr;
        r_halt_d = cerr || (pc_d >= len_q);
        r_ovf_d  = 1'b0;
        r_pc_d   = pc_d;
        if (hold) begin
          tp_d = tp_q;
          pc_d = pc_q;
        end
      end
      U_LOAD: begin
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          prog_we    = 1'b1;
          jt_we      = 1'b1;
          link_pos_d = len_q[PA_W-1:0];
          len_d      = len_q + PC_W'(1);
          if (char_q == CH_OPEN) begin
            stack_we = 1'b1;
            depth_d  = depth_q + PC_W'(1);
          end else if (link) begin
            stack_re = 1'b1;
            depth_d  = depth_dec;
          end
        end
      end
      U_LINK1: begin
        jt_we    = 1'b1;
        jt_waddr = link_pos_q;
        jt_wdata = stack_rd_q;
      end
      U_LINK2: begin
        jt_we    = 1'b1;
        jt_waddr = stack_rd_q;
        jt_wdata = link_pos_q;
      end
      U_CINIT: begin
        len_d   = '0;
        depth_d = '0;
        pc_d    = '0;
        tp_d    = '0;
      end
      U_NOP: begin
        r_emit_d = 1'b0;
        r_byte_d = 8'd0;
        r_cerr_d = 1'b0;
        r_ovf_d  = ovf_q;
        r_halt_d = (pc_q >= len_q);
        r_pc_d   = pc_q;
      end
      default: ;
    endcase

    // post the result word
    if (cw.post && !hold) res_valid_d = 1'b1;

    // a waiting result word keeps its fields
    if (hold) begin
      r_emit_d = r_emit_q;
      r_byte_d = r_byte_q;
      r_halt_d = r_halt_q;
      r_cerr_d = r_cerr_q;
      r_ovf_d  = r_ovf_q;
      r_pc_d   = r_pc_q;
    end

    // step sequencing
    if (!hold) begin
      case (cw.cond)
        C_NEXT:     upc_d = upc_t'(upc_q + 1'b1);
        C_ALWAYS:   upc_d = cw.target;
        C_NOT_LAST: upc_d = sweep_last ? upc_t'(upc_q + 1'b1) : cw.target;
        C_NO_LINK:  upc_d = link ? upc_t'(upc_q + 1'b1) : cw.target;
        C_DISPATCH: begin
          if (accept) begin
            case (func_i)
              FUNC_LOAD:  upc_d = A_LOAD;
              FUNC_EXEC:  upc_d = A_EXEC;
              FUNC_CLEAR: upc_d = A_CINIT;
              default:    upc_d = A_POST;
            endcase
          end
        end
        default:    upc_d = A_FETCH;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= A_RSWEEP;
      sweep_cnt_q <= '0;
      len_q       <= '0;
      depth_q     <= '0;
      pc_q        <= '0;
      tp_q        <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      sweep_cnt_q <= sweep_cnt_d;
      len_q       <= len_d;
      depth_q     <= depth_d;
      pc_q        <= pc_d;
      tp_q        <= tp_d;
      ovf_q       <= ovf_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    link_pos_q <= link_pos_d;
    r_emit_q   <= r_emit_d;
    r_byte_q   <= r_byte_d;
    r_halt_q   <= r_halt_d;
    r_cerr_q   <= r_cerr_d;
    r_ovf_q    <= r_ovf_d;
    r_pc_q     <= r_pc_d;
  end

  // program store
  always_ff @(posedge clk_i) begin
    if (prog_we) prog_mem[len_q[PA_W-1:0]] <= char_q;
    if (fetch_re) prog_rd_q <= prog_mem[pc_q[PA_W-1:0]];
  end

  // jump table
  always_ff @(posedge clk_i) begin
    if (jt_we) jt_mem[jt_waddr] <= jt_wdata;
    if (fetch_re) jt_rd_q <= jt_mem[pc_q[PA_W-1:0]];
  end

  // bracket stack
  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_waddr] <= len_q[PA_W-1:0];
    if (stack_re) stack_rd_q <= stack_mem[stack_raddr];
  end

  // tape
  always_ff @(posedge clk_i) begin
    if (tape_we) tape_mem[tape_waddr] <= tape_wdata;
    if (fetch_re) tape_rd_q <= tape_mem[tp_q];
  end

  assign res_valid_o       = res_valid_q;
  assign out_valid_o       = r_emit_q;
  assign out_byte_o        = r_byte_q;
  assign halted_o          = r_halt_q;
  assign compile_error_o   = r_cerr_q;
  assign load_overflow_o   = r_ovf_q;
  assign program_counter_o = r_pc_q;

endmodule

>>> rtl/bti_checker.sv
module bti_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_stall_o,
  input logic       res_valid_o,
  input logic       res_stall_i,
  input logic       out_valid_o,
  input logic [7:0] out_byte_o,
  input logic       halted_o,
  input logic       compile_error_o,
  input logic       load_overflow_o,
  input logic [bti_pkg::PC_W-1:0] program_counter_o
);
  import bti_pkg::*;

  // a compile error always reports halted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && compile_error_o |-> halted_o)
    else $error("compile error without halted");

  // no output byte unless the word emitted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_byte_o == 8'd0)
    else $error("output byte set without emit");

  // a word carries at most one of emit, compile error, overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $countones({out_valid_o, compile_error_o, load_overflow_o}) <= 1)
    else $error("conflicting status flags");

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(program_counter_o)
      && $stable(halted_o) && $stable(out_byte_o))
    else $error("stalled result word changed");

  // an accepted word keeps the input stalled for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> req_stall_o)
    else $error("back to back accept");

endmodule

bind byte_tape_interpreter_core bti_checker u_bti_checker (.*);

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bti_pkg::*;

  // func code the block leaves unused
  localparam logic [1:0] FUNC_NONE = 2'd3;
  // a command byte without its own package constant
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam int         NUM_DIR   = 25;
  localparam int         RAND_WORDS = 1700;
  localparam int         TAIL_WORDS = 150;

  typedef struct packed {
    logic            out_valid;
    logic [7:0]      out_byte;
    logic            halted;
    logic            compile_error;
    logic            load_overflow;
    logic [PC_W-1:0] program_counter;
  } status_t;

  typedef struct packed {
    logic [1:0] fn;
    logic [7:0] ch;
    logic       typed;
    status_t    want;
  } dir_row_t;

  logic            clk_i;
  logic            rst_ni = 1'b0;
  logic            req_valid_i = 1'b0;
  logic            req_stall_o;
  logic [1:0]      func_i = FUNC_LOAD;
  logic [7:0]      program_char_i = 8'h00;
  logic            res_valid_o;
  logic            res_stall_i = 1'b0;
  logic            out_valid_o;
  logic [7:0]      out_byte_o;
  logic            halted_o;
  logic            compile_error_o;
  logic            load_overflow_o;
  logic [PC_W-1:0] program_counter_o;

  byte_tape_interpreter_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_valid_i),
    .req_stall_o      (req_stall_o),
    .func_i           (func_i),
    .program_char_i   (program_char_i),
    .res_valid_o      (res_valid_o),
    .res_stall_i      (res_stall_i),
    .out_valid_o      (out_valid_o),
    .out_byte_o       (out_byte_o),
    .halted_o         (halted_o),
    .compile_error_o  (compile_error_o),
    .load_overflow_o  (load_overflow_o),
    .program_counter_o(program_counter_o)
  );

  // interpreter state mirrored by the predictor
  logic [7:0]      code_mem   [PROG_DEPTH];
  logic [PA_W-1:0] link_mem   [PROG_DEPTH];
  logic [PA_W-1:0] open_stack [PROG_DEPTH];
  logic [7:0]      cells      [TAPE_DEPTH] = '{default: '0};
  logic [PC_W-1:0] open_depth = '0;
  logic [PC_W-1:0] code_len   = '0;
  logic [PC_W-1:0] code_ip    = '0;
  logic [TA_W-1:0] cell_ptr   = '0;

  status_t step_status_q [$];
  int      fail_count = 0;
  int      words_sent = 0;
  bit      idle_on    = 1'b1;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // status a word leaves behind, applied to the mirrored state
  function automatic status_t interpret_word(logic [1:0] fn, logic [7:0] ch);
    status_t         st;
    logic [PA_W-1:0] at;
    logic [PA_W-1:0] opener;
    logic [PA_W-1:0] pc;
    logic [PC_W-1:0] nxt;
    st = '0;
    case (fn)
      FUNC_LOAD: begin
        if (code_len >= PROG_DEPTH) begin
          st.load_overflow = 1'b1;
        end else begin
          at = code_len[PA_W-1:0];
          code_mem[at] = ch;
          link_mem[at] = '0;
          if (ch == CH_OPEN) begin
            if (open_depth < PROG_DEPTH) begin
              open_stack[open_depth[PA_W-1:0]] = at;
              open_depth = open_depth + 1'b1;
            end
          end else if (ch == CH_CLOSE && open_depth != 0) begin
            // pair with the innermost open bracket
            open_depth = open_depth - 1'b1;
            opener = open_stack[open_depth[PA_W-1:0]];
            link_mem[opener] = at;
            link_mem[at] = opener;
          end
          code_len = code_len + 1'b1;
        end
      end
      FUNC_EXEC: begin
        if (open_depth != 0) begin
          st.compile_error = 1'b1;
        end else if (code_ip < code_len) begin
          pc = code_ip[PA_W-1:0];
          nxt = code_ip + 1'b1;
          case (code_mem[pc])
            CH_RIGHT: cell_ptr = cell_ptr + 1'b1;
            CH_LEFT:  cell_ptr = cell_ptr - 1'b1;
            CH_PLUS:  cells[cell_ptr] = cells[cell_ptr] + 8'd1;
            CH_MINUS: cells[cell_ptr] = cells[cell_ptr] - 8'd1;
            CH_DOT: begin
              st.out_valid = 1'b1;
              st.out_byte = cells[cell_ptr];
            end
            CH_OPEN: begin
              if (cells[cell_ptr] == 8'd0) nxt = {1'b0, link_mem[pc]} + 1'b1;
            end
            CH_CLOSE: begin
              if (cells[cell_ptr] != 8'd0) nxt = {1'b0, link_mem[pc]};
            end
            default: ;
          endcase
          code_ip = nxt;
        end
      end
      FUNC_CLEAR: begin
        cells = '{default: '0};
        code_len = '0;
        open_depth = '0;
        code_ip = '0;
        cell_ptr = '0;
      end
      default: ;
    endcase
    st.halted = st.compile_error || (code_ip >= code_len);
    st.program_counter = code_ip;
    return st;
  endfunction

  function automatic status_t stat(logic ov, logic [7:0] ob, logic h, logic ce, logic of,
                                   logic [PC_W-1:0] pc);
    stat = '{out_valid: ov, out_byte: ob, halted: h, compile_error: ce,
             load_overflow: of, program_counter: pc};
  endfunction

  // plain command most of the time, otherwise any non-bracket byte
  function automatic logic [7:0] body_char();
    logic [7:0] plain [6];
    logic [7:0] c;
    plain = '{CH_RIGHT, CH_LEFT, CH_PLUS, CH_MINUS, CH_DOT, CH_COMMA};
    if ($urandom_range(0, 3) != 0) return plain[$urandom_range(0, 5)];
    do c = 8'($urandom); while (c == CH_OPEN || c == CH_CLOSE);
    return c;
  endfunction

  // present one word, wait for it to be taken, record its status
  task automatic issue_word(input logic [1:0] fn, input logic [7:0] ch,
                            input logic typed, input status_t want);
    status_t st;
    int      gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      req_valid_i <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    func_i <= fn;
    program_char_i <= ch;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    st = interpret_word(fn, ch);
    step_status_q.push_back(typed ? want : st);
    if (fn != FUNC_NONE) words_sent++;
  endtask

  task automatic send_word(input logic [1:0] fn, input logic [7:0] ch);
    issue_word(fn, ch, 1'b0, '0);
  endtask

  // one program fragment, mostly well formed, then a run of steps
  task automatic run_segment();
    logic [7:0] seg [$];
    int         len;
    int         open;
    int         steps;
    int         pick;
    int         i;
    len = $urandom_range(3, 30);
    open = 0;
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        seg.push_back(CH_OPEN);
        open++;
      end else if (pick == 1 && open > 0) begin
        seg.push_back(CH_CLOSE);
        open--;
      end else begin
        seg.push_back(body_char());
      end
    end
    while (open > 0) begin
      seg.push_back(CH_CLOSE);
      open--;
    end
    // now and then leave a bracket open or add a stray close
    pick = $urandom_range(0, 15);
    if (pick == 0 && seg[seg.size()-1] == CH_CLOSE) void'(seg.pop_back());
    else if (pick == 1) seg.push_back(CH_CLOSE);
    foreach (seg[k]) send_word(FUNC_LOAD, seg[k]);
    steps = $urandom_range(5, 60);
    for (i = 0; i < steps; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) send_word(FUNC_NONE, 8'($urandom));
      else if (pick == 1) send_word(FUNC_LOAD, 8'($urandom));
      else send_word(FUNC_EXEC, 8'($urandom));
    end
    // unstick a program left with open brackets
    if (open_depth != 0 && $urandom_range(0, 1) == 0) send_word(FUNC_LOAD, CH_CLOSE);
  endtask

  // receiver stall bursts
  initial begin : result_stall
    int span;
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        res_stall_i <= 1'b1;
        span = $urandom_range(1, 10);
      end else begin
        res_stall_i <= 1'b0;
        span = $urandom_range(1, 12);
      end
      repeat (span) @(posedge clk_i);
    end
  end

  // compare each taken status word against the oldest expectation
  initial begin : status_check
    status_t got;
    status_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_valid_o && !res_stall_i) begin
        got = '{out_valid: out_valid_o, out_byte: out_byte_o, halted: halted_o,
                compile_error: compile_error_o, load_overflow: load_overflow_o,
                program_counter: program_counter_o};
        if (step_status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("status word with nothing expected: pc=%0d", got.program_counter);
        end else begin
          want = step_status_q.pop_front();
          if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
              got.halted !== want.halted || got.compile_error !== want.compile_error ||
              got.load_overflow !== want.load_overflow ||
              got.program_counter !== want.program_counter) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("status mismatch: want ov=%0b byte=%02h halt=%0b cerr=%0b ovf=%0b pc=%0d",
                       want.out_valid, want.out_byte, want.halted, want.compile_error,
                       want.load_overflow, want.program_counter);
              $display("                 got  ov=%0b byte=%02h halt=%0b cerr=%0b ovf=%0b pc=%0d",
                       got.out_valid, got.out_byte, got.halted, got.compile_error,
                       got.load_overflow, got.program_counter);
            end
          end
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    dir_row_t dir_tab [NUM_DIR];
    int       clears_left;
    int       i;
    int       drain;
    dir_tab = '{
      '{FUNC_EXEC,  8'h00,    1'b1, stat(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 13'd0)},
      '{FUNC_NONE,  8'hA5,    1'b1, stat(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 13'd0)},
      '{FUNC_LOAD,  CH_OPEN,  1'b1, stat(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0)},
      '{FUNC_EXEC,  8'h00,    1'b1, stat(1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 13'd0)},
      '{FUNC_LOAD,  CH_RIGHT, 1'b1, stat(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0)},
      '{FUNC_LOAD,  CH_CLOSE, 1'b1, stat(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0)},
      '{FUNC_LOAD,  CH_LEFT,  1'b1, stat(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0)},
      '{FUNC_LOAD,  CH_MINUS, 1'b1, stat(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0)},
      '{FUNC_LOAD,  CH_DOT,   1'b1, stat(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0)},
      '{FUNC_LOAD,  CH_RIGHT, 1'b1, stat(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0)},
      '{FUNC_LOAD,  CH_PLUS,  1'b1, stat(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0)},
      '{FUNC_LOAD,  CH_CLOSE, 1'b1, stat(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0)},
      '{FUNC_LOAD,  8'hFF,    1'b1, stat(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0)},
      // open bracket on a zero cell skips its body
      '{FUNC_EXEC,  8'h00,    1'b0, '0},
      // pointer wraps below zero, cell wraps below zero
      '{FUNC_EXEC,  8'hFF,    1'b0, '0},
      '{FUNC_EXEC,  8'h00,    1'b0, '0},
      '{FUNC_EXEC,  8'h00,    1'b1, stat(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 13'd6)},
      '{FUNC_EXEC,  8'h00,    1'b0, '0},
      '{FUNC_EXEC,  8'h00,    1'b0, '0},
      // unmatched close bracket on a nonzero cell goes back to the start
      '{FUNC_EXEC,  8'h00,    1'b1, stat(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0)},
      '{FUNC_EXEC,  8'h00,    1'b0, '0},
      '{FUNC_EXEC,  8'h00,    1'b0, '0},
      '{FUNC_EXEC,  8'h00,    1'b0, '0},
      '{FUNC_CLEAR, 8'h00,    1'b1, stat(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 13'd0)},
      '{FUNC_EXEC,  8'h00,    1'b1, stat(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 13'd0)}
    };

    // reset, the block's tape sweep shows as stall
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words
    for (i = 0; i < NUM_DIR; i++) begin
      issue_word(dir_tab[i].fn, dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].want);
    end

    // random fragments with occasional clears
    clears_left = 6;
    while (words_sent < NUM_DIR + RAND_WORDS - TAIL_WORDS) begin
      run_segment();
      if (clears_left > 0 && $urandom_range(0, 5) == 0) begin
        send_word(FUNC_CLEAR, 8'($urandom));
        clears_left--;
      end
    end

    // last fragments back to back, no idling on either side
    idle_on = 1'b0;
    while (words_sent < NUM_DIR + RAND_WORDS) run_segment();
    req_valid_i <= 1'b0;

    // drain outstanding status words
    drain = 0;
    while (step_status_q.size() != 0 && drain < 2000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && step_status_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
